>>> design/source_text_tokenizer_assert.svh
// Assertion macros for the source text tokenizer.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define STT_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Condition that must hold on every clock edge outside reset.
`define STT_ASSERT_ALW(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

>>> design/stt_pkg.sv
// Package with token codes, scan modes and shared types of the tokenizer.
package stt_pkg;
  localparam int unsigned MaxKeywordLen = 6;
  localparam int unsigned PositionBits = 24;
  localparam int unsigned LineBits = 24;
  localparam int unsigned OutBits = 24;
  localparam int unsigned QueueDepth = 4;

  localparam logic [5:0] KDot = 6'd9;
  localparam logic [5:0] KSlash = 6'd12;
  localparam logic [5:0] KBang = 6'd14;
  localparam logic [5:0] KEqual = 6'd16;
  localparam logic [5:0] KLess = 6'd18;
  localparam logic [5:0] KGreater = 6'd20;
  localparam logic [5:0] KIdent = 6'd22;
  localparam logic [5:0] KString = 6'd23;
  localparam logic [5:0] KNumber = 6'd24;
  localparam logic [5:0] KAnd = 6'd25;
  localparam logic [5:0] KError = 6'd43;
  localparam logic [5:0] KEnd = 6'd44;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrUnexpected = 2'd1;
  localparam logic [1:0] ErrUnterminated = 2'd2;

  typedef enum logic [3:0] {
    MIdle, MSlash, MComment, MOper, MString, MInt, MDot, MFrac, MIdent
  } mode_e;

  typedef struct packed {
    logic [5:0]         kind;
    logic [1:0]         err;
    logic [OutBits-1:0] off;
    logic [OutBits-1:0] len;
    logic [OutBits-1:0] line;
    logic               last;
  } token_t;

  // Keyword match on the first six identifier bytes; returns KIdent if none.
  function automatic logic [5:0] keyword_kind(input logic [47:0] p, input logic [2:0] n);
    logic [5:0] k;
    k = KIdent;
    case (n)
      3'd2: begin
        if (p[15:0] == "fi") k = 6'd32;
        else if (p[15:0] == "ro") k = 6'd34;
      end
      3'd3: begin
        case (p[23:0])
          "dna": k = 6'd25;
          "rof": k = 6'd30;
          "nuf": k = 6'd31;
          "lin": k = 6'd33;
          "yrt": k = 6'd40;
          "rav": k = 6'd41;
          default: k = KIdent;
        endcase
      end
      3'd4: begin
        case (p[31:0])
          "esle": k = 6'd28;
          "siht": k = 6'd37;
          "eurt": k = 6'd39;
          default: k = KIdent;
        endcase
      end
      3'd5: begin
        case (p[39:0])
          "hctac": k = 6'd26;
          "ssalc": k = 6'd27;
          "eslaf": k = 6'd29;
          "repus": k = 6'd36;
          "worht": k = 6'd38;
          "elihw": k = 6'd42;
          default: k = KIdent;
        endcase
      end
      3'd6: if (p[47:0] == "nruter") k = 6'd35;
      default: k = KIdent;
    endcase
    return k;
  endfunction
endpackage

>>> design/stt_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
interface stt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface stt_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [1:0]  error_kind;
  logic [23:0] token_offset;
  logic [23:0] token_length;
  logic [23:0] token_line;
  logic        last_of_run;
  modport source (output valid, output token_kind, output error_kind, output token_offset,
                  output token_length, output token_line, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input error_kind, input token_offset,
                input token_length, input token_line, input last_of_run, output ready);
endinterface

>>> design/source_text_tokenizer.sv
// Top level of the source text tokenizer.
// Usage:
// The byte channel carries one source byte per transaction; byte 0 ends the
// source text. The token channel carries one token per transaction.
// A byte is taken in every cycle while the token queue has room for three
// tokens; the scanner state machine handles one byte per cycle.
// Tokens caused by a byte are registered in the queue when the byte is taken
// and leave it one per cycle while the receiver is ready, so sustained
// throughput is one byte per cycle if bytes cause at most one token on average.
// A byte may cause up to three tokens; the last carries last_of_run.
// At reset the scanner is idle, the position is zero, the line is one and
// the queue is empty. The end byte returns the scanner to that state.
// When the receiver stalls, tokens wait in the queue and the byte channel
// drops ready once fewer than three entries remain free.
`include "source_text_tokenizer_assert.svh"
module source_text_tokenizer
  import stt_pkg::*;
#(
  parameter int unsigned MAX_KEYWORD_LEN = MaxKeywordLen,
  parameter int unsigned POSITION_BITS = PositionBits,
  parameter int unsigned LINE_BITS = LineBits
) (
  input logic        clk_i,
  input logic        rst_ni,
  stt_byte_if.sink   byte_in,
  stt_token_if.source tok_out
);
  token_t toks [3];
  token_t head;
  logic [1:0] cnt;
  logic any, room, step;

  assign step = byte_in.valid && room;
  assign byte_in.ready = room;

  stt_scanner #(
    .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN),
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS(LINE_BITS)
  ) u_scan (
    .clk_i, .rst_ni, .step_i(step), .char_i(byte_in.char_byte),
    .tok_o(toks), .tok_cnt_o(cnt), .any_o(any)
  );

  stt_token_queue u_queue (
    .clk_i, .rst_ni, .push_i(step && any), .tok_i(toks), .cnt_i(cnt),
    .room_o(room), .valid_o(tok_out.valid), .tok_o(head), .pop_i(tok_out.ready)
  );

  assign tok_out.token_kind = head.kind;
  assign tok_out.error_kind = head.err;
  assign tok_out.token_offset = head.off;
  assign tok_out.token_length = head.len;
  assign tok_out.token_line = head.line;
  assign tok_out.last_of_run = head.last;

  `STT_ASSERT_IMP(a_err_zero, clk_i, rst_ni, tok_out.valid && tok_out.token_kind == KError, tok_out.token_offset == '0 && tok_out.token_length == '0, "error token with nonzero span")
  `STT_ASSERT_IMP(a_end_last, clk_i, rst_ni, tok_out.valid && tok_out.token_kind == KEnd, tok_out.last_of_run, "end token not last of run")
  `STT_ASSERT_IMP(a_cnt_any, clk_i, rst_ni, step, any == (cnt != 2'd0), "token count mismatch")
endmodule

>>> design/stt_scanner.sv
// Front end: scans one byte per cycle when stepped and produces up to three tokens.
module stt_scanner
  import stt_pkg::*;
#(
  parameter int unsigned MAX_KEYWORD_LEN = MaxKeywordLen,
  parameter int unsigned POSITION_BITS = PositionBits,
  parameter int unsigned LINE_BITS = LineBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  output token_t     tok_o [3],
  output logic [1:0] tok_cnt_o,
  output logic       any_o
);
  localparam int unsigned LenBits = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int unsigned IdxBits = $clog2(MAX_KEYWORD_LEN);
  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [LINE_BITS-1:0] LineMax = '1;

  mode_e mode_q, mode_d;
  logic [7:0] op_q, op_d;
  logic [7:0] prefix_q [MAX_KEYWORD_LEN];
  logic [POSITION_BITS-1:0] start_q, start_d, pos_q, pos_d, len_q, len_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic pwr_en;
  logic [IdxBits-1:0] pwr_idx;
  token_t t [3];
  logic [1:0] n;
  logic [47:0] kwp;
  logic [5:0] ikind;

  function automatic logic [POSITION_BITS-1:0] padd(input logic [POSITION_BITS-1:0] a,
                                                     input logic [1:0] b);
    logic [POSITION_BITS:0] s;
    s = {1'b0, a} + {{(POSITION_BITS-1){1'b0}}, b};
    return s[POSITION_BITS] ? PosMax : s[POSITION_BITS-1:0];
  endfunction

  function automatic logic [OutBits-1:0] po(input logic [POSITION_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[OutBits-1:0];
  endfunction

  function automatic logic [5:0] opk(input logic [7:0] c);
    case (c)
      "!": return KBang;
      "=": return KEqual;
      "<": return KLess;
      default: return KGreater;
    endcase
  endfunction

  function automatic logic isd(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic isa(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  always_comb begin
    kwp = '0;
    for (int i = 0; i < 6; i++) begin
      if (i < MAX_KEYWORD_LEN) kwp[i*8 +: 8] = prefix_q[i];
    end
    ikind = (len_q <= POSITION_BITS'(6) && len_q >= POSITION_BITS'(2))
          ? keyword_kind(kwp, len_q[2:0]) : KIdent;
  end

  always_comb begin
    logic idle_scan;
    logic [7:0] c;
    logic [OutBits-1:0] ln;
    c = char_i;
    mode_d = mode_q; op_d = op_q; start_d = start_q; len_d = len_q; line_d = line_q;
    pos_d = pos_q; pwr_en = 1'b0; pwr_idx = '0;
    n = 2'd0; idle_scan = 1'b0;
    for (int i = 0; i < 3; i++) t[i] = '0;
    ln = OutBits'(32'(line_q));
    if (c == 8'd0) begin
      case (mode_q)
        MSlash: begin t[0] = '{KSlash, ErrNone, po(start_q), 24'd1, ln, 1'b0}; n = 2'd1; end
        MOper: begin t[0] = '{opk(op_q), ErrNone, po(start_q), 24'd1, ln, 1'b0}; n = 2'd1; end
        MString: begin t[0] = '{KError, ErrUnterminated, '0, '0, ln, 1'b0}; n = 2'd1; end
        MInt, MFrac: begin
          t[0] = '{KNumber, ErrNone, po(start_q), po(len_q), ln, 1'b0}; n = 2'd1;
        end
        MDot: begin
          t[0] = '{KNumber, ErrNone, po(start_q), po(len_q), ln, 1'b0};
          t[1] = '{KDot, ErrNone, po(padd(start_q, 2'd0) + len_q < start_q ? PosMax :
                   start_q + len_q), 24'd1, ln, 1'b0};
          n = 2'd2;
        end
        MIdent: begin t[0] = '{ikind, ErrNone, po(start_q), po(len_q), ln, 1'b0}; n = 2'd1; end
        default: n = 2'd0;
      endcase
      t[n] = '{KEnd, ErrNone, po(pos_q), '0, ln, 1'b0};
      n = n + 2'd1;
      mode_d = MIdle; op_d = '0; start_d = '0; pos_d = '0; line_d = LINE_BITS'(1); len_d = '0;
    end else begin
      case (mode_q)
        MSlash: begin
          if (c == "/") mode_d = MComment;
          else begin
            t[0] = '{KSlash, ErrNone, po(start_q), 24'd1, ln, 1'b0}; n = 2'd1; idle_scan = 1'b1;
          end
        end
        MComment: if (c == 8'h0a) idle_scan = 1'b1;
        MOper: begin
          if (c == "=") begin
            t[0] = '{opk(op_q) + 6'd1, ErrNone, po(start_q), 24'd2, ln, 1'b0}; n = 2'd1;
            mode_d = MIdle;
          end else begin
            t[0] = '{opk(op_q), ErrNone, po(start_q), 24'd1, ln, 1'b0}; n = 2'd1;
            idle_scan = 1'b1;
          end
        end
        MString: begin
          len_d = padd(len_q, 2'd1);
          if (c == "\"") begin
            t[0] = '{KString, ErrNone, po(start_q), po(len_d), ln, 1'b0}; n = 2'd1;
            mode_d = MIdle;
          end else if (c == 8'h0a) begin
            line_d = (line_q == LineMax) ? line_q : line_q + LINE_BITS'(1);
          end
        end
        MInt: begin
          if (isd(c)) len_d = padd(len_q, 2'd1);
          else if (c == ".") mode_d = MDot;
          else begin
            t[0] = '{KNumber, ErrNone, po(start_q), po(len_q), ln, 1'b0}; n = 2'd1;
            idle_scan = 1'b1;
          end
        end
        MDot: begin
          if (isd(c)) begin len_d = padd(len_q, 2'd2); mode_d = MFrac; end
          else begin
            t[0] = '{KNumber, ErrNone, po(start_q), po(len_q), ln, 1'b0};
            t[1] = '{KDot, ErrNone, po((({1'b0, start_q} + {1'b0, len_q}) >> POSITION_BITS) != 0
                     ? PosMax : start_q + len_q), 24'd1, ln, 1'b0};
            n = 2'd2; idle_scan = 1'b1;
          end
        end
        MFrac: begin
          if (isd(c)) len_d = padd(len_q, 2'd1);
          else begin
            t[0] = '{KNumber, ErrNone, po(start_q), po(len_q), ln, 1'b0}; n = 2'd1;
            idle_scan = 1'b1;
          end
        end
        MIdent: begin
          if (isa(c) || isd(c)) begin
            if (len_q < POSITION_BITS'(MAX_KEYWORD_LEN)) begin
              pwr_en = 1'b1; pwr_idx = len_q[IdxBits-1:0];
            end
            len_d = padd(len_q, 2'd1);
          end else begin
            t[0] = '{ikind, ErrNone, po(start_q), po(len_q), ln, 1'b0}; n = 2'd1;
            idle_scan = 1'b1;
          end
        end
        default: idle_scan = 1'b1;
      endcase
      if (idle_scan) begin
        mode_d = MIdle;
        if (c == " " || c == 8'h0d || c == 8'h09) begin
          mode_d = MIdle;
        end else if (c == 8'h0a) begin
          line_d = (line_q == LineMax) ? line_q : line_q + LINE_BITS'(1);
        end else if (isd(c) || isa(c) || c == "/" || c == "\"" ||
                     c == "!" || c == "=" || c == "<" || c == ">") begin
          start_d = pos_q; len_d = POSITION_BITS'(1);
          if (isd(c)) mode_d = MInt;
          else if (isa(c)) begin mode_d = MIdent; pwr_en = 1'b1; pwr_idx = '0; end
          else if (c == "/") mode_d = MSlash;
          else if (c == "\"") mode_d = MString;
          else begin mode_d = MOper; op_d = c; end
        end else begin
          case (c)
            "(": t[n] = '{6'd0, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            ")": t[n] = '{6'd1, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            "{": t[n] = '{6'd2, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            "}": t[n] = '{6'd3, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            "[": t[n] = '{6'd4, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            "]": t[n] = '{6'd5, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            ";": t[n] = '{6'd6, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            ":": t[n] = '{6'd7, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            ",": t[n] = '{6'd8, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            ".": t[n] = '{KDot, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            "-": t[n] = '{6'd10, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            "+": t[n] = '{6'd11, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            "*": t[n] = '{6'd13, ErrNone, po(pos_q), 24'd1, ln, 1'b0};
            default: t[n] = '{KError, ErrUnexpected, '0, '0, ln, 1'b0};
          endcase
          n = n + 2'd1;
        end
      end
      pos_d = padd(pos_q, 2'd1);
    end
    if (n != 2'd0) t[n - 2'd1].last = 1'b1;
  end

  assign tok_o = t;
  assign tok_cnt_o = n;
  assign any_o = (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle; op_q <= '0; start_q <= '0; pos_q <= '0;
      line_q <= LINE_BITS'(1); len_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d; op_q <= op_d; start_q <= start_d; pos_q <= pos_d;
      line_q <= line_d; len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && pwr_en) prefix_q[pwr_idx] <= char_i;
  end
endmodule

>>> design/stt_token_queue.sv
// Token queue between scanner and output: takes up to three tokens, gives one.
module stt_token_queue
  import stt_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth + 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  token_t     tok_i [3],
  input  logic [1:0] cnt_i,
  output logic       room_o,
  output logic       valid_o,
  output token_t     tok_o,
  input  logic       pop_i
);
  localparam int unsigned AW = $clog2(DEPTH);
  token_t mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] fill_q, fill_d;
  logic do_pop;

  assign valid_o = fill_q != '0;
  assign tok_o = mem_q[rp_q];
  assign do_pop = pop_i && valid_o;
  assign room_o = fill_q <= (AW+1)'(DEPTH - 3);

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p, input logic [1:0] k);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(k);
    return (s >= (AW+1)'(DEPTH)) ? AW'(s - (AW+1)'(DEPTH)) : s[AW-1:0];
  endfunction

  always_comb begin
    fill_d = fill_q;
    if (push_i) fill_d = fill_d + (AW+1)'(cnt_i);
    if (do_pop) fill_d = fill_d - (AW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; fill_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (push_i) wp_q <= nxt(wp_q, cnt_i);
      if (do_pop) rp_q <= nxt(rp_q, 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < cnt_i) mem_q[nxt(wp_q, 2'(i))] <= tok_i[i];
      end
    end
  end
endmodule
